/* hw/rtl/agbc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agbc_pkg: accel and gyro bias calibration shared definitions
// types, register indexes, state codes and width helpers for the block
// ----------------------------------------------------------------------------
package agbc_pkg;

   localparam int MAX_PACKETS_DEF = 256;

   localparam int DATA_W     = 16;
   localparam int GRAV_W     = 15;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int AXES       = 6;
   localparam int ACCEL_AXES = 3;
   localparam int AXIS_W     = 3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TRIM_X  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TRIM_Y  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TRIM_Z  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GRAVITY = 2'd3;

   localparam logic [GRAV_W-1:0] GRAVITY_RESET = 15'd16384;

   // axis codes: accel x,y,z then gyro x,y,z
   localparam logic [AXIS_W-1:0] AXIS_AX = 3'd0;
   localparam logic [AXIS_W-1:0] AXIS_AY = 3'd1;
   localparam logic [AXIS_W-1:0] AXIS_AZ = 3'd2;
   localparam logic [AXIS_W-1:0] AXIS_GX = 3'd3;
   localparam logic [AXIS_W-1:0] AXIS_GY = 3'd4;
   localparam logic [AXIS_W-1:0] AXIS_GZ = 3'd5;

   // saturation limits of the 16-bit average, as magnitudes and as values
   localparam int SAT_POS_MAG = 32767;
   localparam int SAT_NEG_MAG = 32768;
   localparam logic signed [DATA_W-1:0] AVG_MAX = 16'sh7FFF;
   localparam logic signed [DATA_W-1:0] AVG_MIN = 16'sh8000;

   function automatic int sum_width(input int max_packets);
      return DATA_W + $clog2(max_packets);
   endfunction

   function automatic int cnt_width(input int max_packets);
      return $clog2(max_packets + 1);
   endfunction

   function automatic int prod_width(input int max_packets);
      return cnt_width(max_packets) + GRAV_W;
   endfunction

   // signed width of a sum after gravity removal
   function automatic int adj_width(input int max_packets);
      int s;
      int p;
      s = sum_width(max_packets);
      p = prod_width(max_packets) + 1;
      return ((s > p) ? s : p) + 1;
   endfunction

   typedef struct packed {
      logic signed [DATA_W-1:0] accel_x;
      logic signed [DATA_W-1:0] accel_y;
      logic signed [DATA_W-1:0] accel_z;
      logic signed [DATA_W-1:0] gyro_x;
      logic signed [DATA_W-1:0] gyro_y;
      logic signed [DATA_W-1:0] gyro_z;
      logic                     last_packet;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] accel_offset_x;
      logic [DATA_W-1:0] accel_offset_y;
      logic [DATA_W-1:0] accel_offset_z;
      logic [DATA_W-1:0] gyro_offset_x;
      logic [DATA_W-1:0] gyro_offset_y;
      logic [DATA_W-1:0] gyro_offset_z;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MULT,
      ST_LOAD,
      ST_ABS,
      ST_DIV,
      ST_STORE,
      ST_OUT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic              accum;
      logic              mult;
      logic              load;
      logic              abs;
      logic              step;
      logic              store;
      logic              out_load;
      logic              clear;
      logic [AXIS_W-1:0] axis;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
   } sts_type;

endpackage

/* hw/rtl/agbc_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agbc_ctrl: calibration sequencer
// accepts packets, then walks the six axes through the shared divider
// ----------------------------------------------------------------------------
module agbc_ctrl #(
   parameter int MAX_PACKETS = agbc_pkg::MAX_PACKETS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_last,
   output logic               req_stall,
   input  agbc_pkg::sts_type  sts,
   output agbc_pkg::cmd_type  cmd
);

   localparam int MAG_W  = agbc_pkg::adj_width(MAX_PACKETS);
   localparam int STEP_W = $clog2(MAG_W);

   agbc_pkg::state_type           state_ff, state_in;
   logic [agbc_pkg::AXIS_W-1:0]   axis_ff, axis_in;
   logic [STEP_W-1:0]             step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= agbc_pkg::ST_IDLE;
         axis_ff  <= agbc_pkg::AXIS_AX;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      axis_in   = axis_ff;
      step_in   = step_ff;
      req_stall = 1'b1;
      cmd       = '0;
      cmd.axis  = axis_ff;
      unique case (state_ff)
         agbc_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accum = 1'b1;
               if (req_last) begin
                  state_in = agbc_pkg::ST_MULT;
               end
            end
         end
         agbc_pkg::ST_MULT: begin
            cmd.mult = 1'b1;
            axis_in  = agbc_pkg::AXIS_AX;
            state_in = agbc_pkg::ST_LOAD;
         end
         agbc_pkg::ST_LOAD: begin
            cmd.load = 1'b1;
            state_in = agbc_pkg::ST_ABS;
         end
         agbc_pkg::ST_ABS: begin
            cmd.abs  = 1'b1;
            step_in  = '0;
            state_in = agbc_pkg::ST_DIV;
         end
         agbc_pkg::ST_DIV: begin
            cmd.step = 1'b1;
            if (step_ff == STEP_W'(MAG_W - 1)) begin
               state_in = agbc_pkg::ST_STORE;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         agbc_pkg::ST_STORE: begin
            cmd.store = 1'b1;
            if (axis_ff == agbc_pkg::AXIS_GZ) begin
               state_in = agbc_pkg::ST_OUT;
            end else begin
               axis_in  = axis_ff + 1'b1;
               state_in = agbc_pkg::ST_LOAD;
            end
         end
         agbc_pkg::ST_OUT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               cmd.clear    = 1'b1;
               state_in     = agbc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = agbc_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

/* hw/rtl/agbc_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agbc_datapath: sums, gravity removal, divider and offset words
// holds the config registers, axis sums, restoring divider and output register
// ----------------------------------------------------------------------------
module agbc_datapath #(
   parameter int MAX_PACKETS = agbc_pkg::MAX_PACKETS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  agbc_pkg::cmd_type                 cmd,
   output agbc_pkg::sts_type                 sts,
   input  agbc_pkg::req_type                 req_data,
   input  logic                              rsp_stall,
   output logic                              rsp_valid,
   output agbc_pkg::rsp_type                 rsp_data,
   input  logic                              csr_write,
   input  logic [agbc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [agbc_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int DW     = agbc_pkg::DATA_W;
   localparam int SUM_W  = agbc_pkg::sum_width(MAX_PACKETS);
   localparam int CNT_W  = agbc_pkg::cnt_width(MAX_PACKETS);
   localparam int PROD_W = agbc_pkg::prod_width(MAX_PACKETS);
   localparam int ADJ_W  = agbc_pkg::adj_width(MAX_PACKETS);
   localparam int MAG_W  = ADJ_W;

   logic [DW-1:0]                  trim_ff [agbc_pkg::ACCEL_AXES];
   logic [agbc_pkg::GRAV_W-1:0]    grav_ff;
   logic signed [SUM_W-1:0]        sums_ff [agbc_pkg::AXES];
   logic [CNT_W-1:0]               count_ff;
   logic [PROD_W-1:0]              prod_ff;
   logic signed [ADJ_W-1:0]        adj_ff, adj_in;
   logic [MAG_W-1:0]               quo_ff;
   logic [CNT_W-1:0]               rem_ff, rem_in;
   logic                           quo_bit_in;
   logic                           neg_ff;
   logic signed [DW-1:0]           avg_ff [agbc_pkg::AXES];
   logic signed [DW-1:0]           avg_in;
   logic                           rsp_valid_ff;
   agbc_pkg::rsp_type              rsp_data_ff, rsp_in;

   logic signed [DW-1:0]           sample [agbc_pkg::AXES];
   logic signed [ADJ_W-1:0]        sel_ext, prod_ext;
   logic [CNT_W:0]                 trial;
   logic signed [DW-1:0]           acc_diff [agbc_pkg::ACCEL_AXES];
   logic [DW-1:0]                  acc_word [agbc_pkg::ACCEL_AXES];
   logic signed [DW:0]             gneg [agbc_pkg::ACCEL_AXES];
   logic signed [DW:0]             gquo [agbc_pkg::ACCEL_AXES];

   assign sample[0] = req_data.accel_x;
   assign sample[1] = req_data.accel_y;
   assign sample[2] = req_data.accel_z;
   assign sample[3] = req_data.gyro_x;
   assign sample[4] = req_data.gyro_y;
   assign sample[5] = req_data.gyro_z;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < agbc_pkg::ACCEL_AXES; i++) begin
            trim_ff[i] <= '0;
         end
         grav_ff <= agbc_pkg::GRAVITY_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            agbc_pkg::CSR_TRIM_X:  trim_ff[0] <= csr_wdata;
            agbc_pkg::CSR_TRIM_Y:  trim_ff[1] <= csr_wdata;
            agbc_pkg::CSR_TRIM_Z:  trim_ff[2] <= csr_wdata;
            agbc_pkg::CSR_GRAVITY: grav_ff    <= csr_wdata[agbc_pkg::GRAV_W-1:0];
            default: ;
         endcase
      end
   end

   // running sums and packet count, saturating count stops summing
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         for (int i = 0; i < agbc_pkg::AXES; i++) begin
            sums_ff[i] <= '0;
         end
         count_ff <= '0;
      end else if (cmd.accum && (count_ff < CNT_W'(MAX_PACKETS))) begin
         for (int i = 0; i < agbc_pkg::AXES; i++) begin
            sums_ff[i] <= sums_ff[i] + SUM_W'(sample[i]);
         end
         count_ff <= count_ff + 1'b1;
      end
   end

   // gravity removal on z accel
   always_comb begin
      sel_ext  = ADJ_W'(sums_ff[cmd.axis]);
      prod_ext = $signed(ADJ_W'(prod_ff));
      if (cmd.axis == agbc_pkg::AXIS_AZ) begin
         adj_in = (sel_ext > ADJ_W'(0)) ? sel_ext - prod_ext : sel_ext + prod_ext;
      end else begin
         adj_in = sel_ext;
      end
   end

   // one restoring divider step
   always_comb begin
      trial = {rem_ff, quo_ff[MAG_W-1]};
      if (trial >= {1'b0, count_ff}) begin
         rem_in     = CNT_W'(trial - {1'b0, count_ff});
         quo_bit_in = 1'b1;
      end else begin
         rem_in     = trial[CNT_W-1:0];
         quo_bit_in = 1'b0;
      end
   end

   // signed, saturated average
   always_comb begin
      if (!neg_ff) begin
         avg_in = (quo_ff > MAG_W'(agbc_pkg::SAT_POS_MAG)) ?
                  agbc_pkg::AVG_MAX : $signed(quo_ff[DW-1:0]);
      end else begin
         avg_in = (quo_ff > MAG_W'(agbc_pkg::SAT_NEG_MAG)) ?
                  agbc_pkg::AVG_MIN : -$signed(quo_ff[DW-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mult) begin
         prod_ff <= PROD_W'(count_ff) * PROD_W'(grav_ff);
      end
      if (cmd.load) begin
         adj_ff <= adj_in;
      end
      if (cmd.abs) begin
         neg_ff <= adj_ff[ADJ_W-1];
         quo_ff <= MAG_W'(adj_ff[ADJ_W-1] ? -adj_ff : adj_ff);
         rem_ff <= '0;
      end else if (cmd.step) begin
         quo_ff <= {quo_ff[MAG_W-2:0], quo_bit_in};
         rem_ff <= rem_in;
      end
      if (cmd.store) begin
         avg_ff[cmd.axis] <= avg_in;
      end
   end

   // offset words
   always_comb begin
      for (int i = 0; i < agbc_pkg::ACCEL_AXES; i++) begin
         acc_diff[i] = $signed(trim_ff[i]) - (avg_ff[i] >>> 3);
         acc_word[i] = {acc_diff[i][DW-1:1], trim_ff[i][0]};
         gneg[i]     = -((DW + 1)'(avg_ff[agbc_pkg::ACCEL_AXES + i]));
         gquo[i]     = gneg[i][DW] ? ((gneg[i] + 17'sd3) >>> 2) : (gneg[i] >>> 2);
      end
      rsp_in.accel_offset_x = acc_word[0];
      rsp_in.accel_offset_y = acc_word[1];
      rsp_in.accel_offset_z = acc_word[2];
      rsp_in.gyro_offset_x  = gquo[0][DW-1:0];
      rsp_in.gyro_offset_y  = gquo[1][DW-1:0];
      rsp_in.gyro_offset_z  = gquo[2][DW-1:0];
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign sts.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;

endmodule

/* hw/rtl/accel_gyro_bias_calibration.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_gyro_bias_calibration: accel and gyro bias calibration
// sums sensor packets per axis and turns the averages into offset words
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake              payload
//  req      in         req_valid / req_stall  agbc_pkg::req_type (six samples, last flag)
//  rsp      out        rsp_valid / rsp_stall  agbc_pkg::rsp_type (six offset words)
//  csr      in         csr_write              csr_index, csr_wdata (trims, gravity count)
//
//  an ordinary packet is taken in one cycle, and packets may come back to back
//  a last packet holds req_stall through the gravity product, then load, abs,
//  divide and store for each axis and the output load; the one-bit-per-cycle
//  restoring divider, MAG_W bits wide (26 at 256 packets) and shared by all six axes,
//  sets the stall's length, longer while the previous result still waits on rsp_stall
//  a result waiting on rsp_stall does not block ordinary packets
//  reset is synchronous, clears sums, count, trims and the sequencer, and sets gravity to its reset value
//
module accel_gyro_bias_calibration #(
   parameter int MAX_PACKETS = agbc_pkg::MAX_PACKETS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // packet input
   input  logic                              req_valid,
   output logic                              req_stall,
   input  agbc_pkg::req_type                 req_data,
   // offset words
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output agbc_pkg::rsp_type                 rsp_data,
   // register writes
   input  logic                              csr_write,
   input  logic [agbc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [agbc_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   agbc_pkg::cmd_type cmd;
   agbc_pkg::sts_type sts;

   // sequencer: takes packets, forms the gravity product, then steps each axis
   // through load, abs, divide and store, and finally loads the output register
   agbc_ctrl #(
      .MAX_PACKETS (MAX_PACKETS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.last_packet),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: config registers, sums, gravity removal, divider, offsets
   agbc_datapath #(
      .MAX_PACKETS (MAX_PACKETS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

endmodule

/* hw/rtl/agbc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agbc_checker: port-level checks for the calibration block
// watches the handshakes and the busy window after a last packet
// ----------------------------------------------------------------------------
module agbc_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input agbc_pkg::req_type                 req_data,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input agbc_pkg::rsp_type                 rsp_data,
   input logic                              csr_write,
   input logic [agbc_pkg::CSR_IDX_W-1:0]    csr_index,
   input logic [agbc_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   logic last_taken;

   assign last_taken = req_valid && !req_stall && req_data.last_packet;

   // a stalled result stays
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp item dropped while stalled");

   // a stalled result keeps its words
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("rsp item changed while stalled");

   // the divide pass keeps input closed right after a last packet
   assert property (@(posedge clock) disable iff (reset)
      last_taken |=> req_stall ##1 req_stall)
      else $error("packet taken during divide pass");

   // a new result only comes out of the busy window
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without a divide pass");

   // register writes land only while the sequencer is idle, with known values
   assert property (@(posedge clock) disable iff (reset)
      csr_write |-> !req_stall && !$isunknown({csr_index, csr_wdata}))
      else $error("register write while busy or with unknown value");

endmodule

bind accel_gyro_bias_calibration agbc_checker u_agbc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data),
   .csr_write (csr_write),
   .csr_index (csr_index),
   .csr_wdata (csr_wdata)
);
